/* sv/ps2d_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ps2d_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CHAR_W     = 7;
  localparam int KEY_W      = 6;
  localparam int SCAN_W     = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENTER = 2'd0,
    CFG_BKSP  = 2'd1,
    CFG_TAB   = 2'd2,
    CFG_ESC   = 2'd3
  } cfg_idx_t;

  localparam logic [SCAN_W-1:0] CODE_EXT    = 8'hE0;
  localparam logic [SCAN_W-1:0] CODE_PAUSE  = 8'hE1;

  localparam logic [KEY_W-1:0] KEY_UNMAPPED = 6'd0;
  localparam logic [KEY_W-1:0] KEY_ESC      = 6'd1;
  localparam logic [KEY_W-1:0] KEY_BKSP     = 6'd12;
  localparam logic [KEY_W-1:0] KEY_TAB      = 6'd13;
  localparam logic [KEY_W-1:0] KEY_RETURN   = 6'd24;
  localparam logic [KEY_W-1:0] KEY_LSH      = 6'd34;
  localparam logic [KEY_W-1:0] KEY_RSH      = 6'd42;
  localparam logic [KEY_W-1:0] KEY_ALT      = 6'd43;
  localparam logic [KEY_W-1:0] KEY_CAPS     = 6'd45;
  localparam logic [KEY_W-1:0] KEY_ARROW_UP = 6'd58;
  localparam logic [KEY_W-1:0] KEY_ARROW_DN = 6'd59;
  localparam logic [KEY_W-1:0] KEY_ARROW_LT = 6'd60;
  localparam logic [KEY_W-1:0] KEY_ARROW_RT = 6'd61;
  localparam logic [KEY_W-1:0] KEY_CTRL     = 6'd62;
  localparam logic [KEY_W-1:0] KEY_MAX      = 6'd62;

  // One classified key event on its way from the front to the back.
  typedef struct packed {
    logic              is_release;
    logic [KEY_W-1:0]  key_id;
    logic [CHAR_W-1:0] fixed_char;
  } ps2d_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ps2d_queue_status_t;

  function automatic logic [KEY_W-1:0] base_lookup(input logic [6:0] code);
    logic [KEY_W-1:0] key;
    key = KEY_UNMAPPED;
    unique case (code) inside
      7'h01:           key = KEY_ESC;
      [7'h02:7'h0B]:   key = KEY_W'(code);
      7'h0E:           key = KEY_BKSP;
      7'h0F:           key = KEY_TAB;
      [7'h10:7'h19]:   key = KEY_W'(code - 7'd2);
      7'h1C:           key = KEY_RETURN;
      [7'h1E:7'h26]:   key = KEY_W'(code - 7'd5);
      7'h2A:           key = KEY_LSH;
      [7'h2C:7'h32]:   key = KEY_W'(code - 7'd9);
      7'h36:           key = KEY_RSH;
      7'h38:           key = KEY_ALT;
      7'h39:           key = 6'd44;
      7'h3A:           key = KEY_CAPS;
      [7'h3B:7'h44]:   key = KEY_W'(code - 7'd13);
      7'h57:           key = 6'd56;
      7'h58:           key = 6'd57;
      default:         key = KEY_UNMAPPED;
    endcase
    return key;
  endfunction

  function automatic logic [KEY_W-1:0] ext_lookup(input logic [6:0] code);
    logic [KEY_W-1:0] key;
    key = KEY_UNMAPPED;
    unique case (code)
      7'h48:   key = KEY_ARROW_UP;
      7'h50:   key = KEY_ARROW_DN;
      7'h4B:   key = KEY_ARROW_LT;
      7'h4D:   key = KEY_ARROW_RT;
      7'h1D:   key = KEY_CTRL;
      7'h38:   key = KEY_ALT;
      default: key = KEY_UNMAPPED;
    endcase
    return key;
  endfunction

  // Unshifted character of a key: lowercase letters, digits and space.
  function automatic logic [CHAR_W-1:0] plain_char(input logic [KEY_W-1:0] key);
    logic [CHAR_W-1:0] c;
    c = 7'h00;
    unique case (key)
      6'd2:  c = 7'h31;
      6'd3:  c = 7'h32;
      6'd4:  c = 7'h33;
      6'd5:  c = 7'h34;
      6'd6:  c = 7'h35;
      6'd7:  c = 7'h36;
      6'd8:  c = 7'h37;
      6'd9:  c = 7'h38;
      6'd10: c = 7'h39;
      6'd11: c = 7'h30;
      6'd14: c = 7'h71;
      6'd15: c = 7'h77;
      6'd16: c = 7'h65;
      6'd17: c = 7'h72;
      6'd18: c = 7'h74;
      6'd19: c = 7'h79;
      6'd20: c = 7'h75;
      6'd21: c = 7'h69;
      6'd22: c = 7'h6F;
      6'd23: c = 7'h70;
      6'd25: c = 7'h61;
      6'd26: c = 7'h73;
      6'd27: c = 7'h64;
      6'd28: c = 7'h66;
      6'd29: c = 7'h67;
      6'd30: c = 7'h68;
      6'd31: c = 7'h6A;
      6'd32: c = 7'h6B;
      6'd33: c = 7'h6C;
      6'd35: c = 7'h7A;
      6'd36: c = 7'h78;
      6'd37: c = 7'h63;
      6'd38: c = 7'h76;
      6'd39: c = 7'h62;
      6'd40: c = 7'h6E;
      6'd41: c = 7'h6D;
      6'd44: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] shifted_digit(input logic [KEY_W-1:0] key);
    logic [CHAR_W-1:0] c;
    c = 7'h00;
    unique case (key)
      6'd2:  c = 7'h21;
      6'd3:  c = 7'h40;
      6'd4:  c = 7'h23;
      6'd5:  c = 7'h24;
      6'd6:  c = 7'h25;
      6'd7:  c = 7'h5E;
      6'd8:  c = 7'h26;
      6'd9:  c = 7'h2A;
      6'd10: c = 7'h28;
      6'd11: c = 7'h29;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/ps2d_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module ps2d_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ps2d_pkg::SCAN_W-1:0]   scan_byte,
  input  wire ps2d_pkg::ps2d_queue_status_t  q_status,
  output logic                               push,
  output ps2d_pkg::ps2d_item_t               push_item
);

  logic prefix_pending;
  logic left_shift_held, right_shift_held, ctrl_held, caps_active;
  logic left_shift_next, right_shift_next, ctrl_next, caps_next;

  logic                            accept;
  logic                            is_ext, is_pause, release_bit;
  logic [6:0]                      code;
  logic [ps2d_pkg::KEY_W-1:0]      key;
  logic                            key_hit;
  logic                            shift_next;
  logic [ps2d_pkg::CHAR_W-1:0]     plain, char_sel;
  logic                            is_letter, is_digit_key;

  assign in_stall    = q_status.full;
  assign accept      = in_valid && !q_status.full;
  assign is_ext      = (scan_byte == ps2d_pkg::CODE_EXT);
  assign is_pause    = (scan_byte == ps2d_pkg::CODE_PAUSE);
  assign release_bit = scan_byte[7];
  assign code        = scan_byte[6:0];
  assign key         = prefix_pending ? ps2d_pkg::ext_lookup(code)
                                      : ps2d_pkg::base_lookup(code);
  assign key_hit     = (key != ps2d_pkg::KEY_UNMAPPED) && !is_ext && !is_pause;

  // Modifier state as it stands once this byte has taken effect.
  always_comb begin
    left_shift_next  = left_shift_held;
    right_shift_next = right_shift_held;
    ctrl_next        = ctrl_held;
    caps_next        = caps_active;
    if (key_hit) begin
      case (key)
        ps2d_pkg::KEY_LSH:  left_shift_next  = !release_bit;
        ps2d_pkg::KEY_RSH:  right_shift_next = !release_bit;
        ps2d_pkg::KEY_CTRL: ctrl_next        = !release_bit;
        ps2d_pkg::KEY_CAPS: if (!release_bit) caps_next = !caps_active;
        default: ;
      endcase
    end
  end

  assign shift_next   = left_shift_next || right_shift_next;
  assign plain        = ps2d_pkg::plain_char(key);
  assign is_letter    = (plain >= 7'h61) && (plain <= 7'h7A);
  assign is_digit_key = (key >= 6'd2) && (key <= 6'd11);

  always_comb begin
    if (release_bit) begin
      char_sel = '0;
    end else if (is_letter) begin
      if (ctrl_next) begin
        char_sel = plain - 7'h60;
      end else if (shift_next != caps_next) begin
        char_sel = plain - 7'h20;
      end else begin
        char_sel = plain;
      end
    end else if (shift_next && is_digit_key) begin
      char_sel = ps2d_pkg::shifted_digit(key);
    end else begin
      char_sel = plain;
    end
  end

  assign push                 = accept && key_hit;
  assign push_item.is_release = release_bit;
  assign push_item.key_id     = key;
  assign push_item.fixed_char = char_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_pending   <= 1'b0;
      left_shift_held  <= 1'b0;
      right_shift_held <= 1'b0;
      ctrl_held        <= 1'b0;
      caps_active      <= 1'b0;
    end else if (accept) begin
      if (is_ext) begin
        prefix_pending <= 1'b1;
      end else begin
        // Any other byte, mapped or not, consumes the prefix.
        prefix_pending   <= 1'b0;
        left_shift_held  <= left_shift_next;
        right_shift_held <= right_shift_next;
        ctrl_held        <= ctrl_next;
        caps_active      <= caps_next;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/ps2d_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module ps2d_queue #(
  parameter int DEPTH = ps2d_pkg::QUEUE_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire ps2d_pkg::ps2d_item_t         push_item,
  input  wire logic                         pop,
  output ps2d_pkg::ps2d_item_t              pop_item,
  output ps2d_pkg::ps2d_queue_status_t      status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ps2d_pkg::ps2d_item_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign pop_item     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* sv/ps2d_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module ps2d_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ps2d_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ps2d_pkg::CHAR_W-1:0]      cfg_data,
  input  wire ps2d_pkg::ps2d_queue_status_t     q_status,
  input  wire ps2d_pkg::ps2d_item_t             pop_item,
  output logic                                  pop,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  is_release,
  output logic [ps2d_pkg::KEY_W-1:0]            key_id,
  output logic [ps2d_pkg::CHAR_W-1:0]           ascii_char
);

  logic [ps2d_pkg::CHAR_W-1:0] enter_char, backspace_char, tab_char, escape_char;
  logic [ps2d_pkg::CHAR_W-1:0] char_sel;
  logic                        load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enter_char     <= 7'd10;
      backspace_char <= 7'd8;
      tab_char       <= 7'd9;
      escape_char    <= 7'd27;
    end else if (cfg_valid) begin
      unique case (ps2d_pkg::cfg_idx_t'(cfg_index))
        ps2d_pkg::CFG_ENTER: enter_char     <= cfg_data;
        ps2d_pkg::CFG_BKSP:  backspace_char <= cfg_data;
        ps2d_pkg::CFG_TAB:   tab_char       <= cfg_data;
        ps2d_pkg::CFG_ESC:   escape_char    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Configured characters replace the fixed one on a press, as written.
  always_comb begin
    char_sel = pop_item.fixed_char;
    if (!pop_item.is_release) begin
      case (pop_item.key_id)
        ps2d_pkg::KEY_RETURN: char_sel = enter_char;
        ps2d_pkg::KEY_BKSP:   char_sel = backspace_char;
        ps2d_pkg::KEY_TAB:    char_sel = tab_char;
        ps2d_pkg::KEY_ESC:    char_sel = escape_char;
        default: ;
      endcase
    end
  end

  assign load = !out_valid || !out_stall;
  assign pop  = load && !q_status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= !q_status.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      is_release <= pop_item.is_release;
      key_id     <= pop_item.key_id;
      ascii_char <= char_sel;
    end
  end

endmodule

`default_nettype wire

/* sv/ps2_set1_scancode_decoder_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    scan_byte[7:0]
// out       output     out_valid / out_stall  is_release, key_id[5:0], ascii_char[6:0]
// cfg       input      cfg_valid / cfg_ready  cfg_index[1:0], cfg_data[6:0]
//
// One scancode byte is taken every cycle unless in_stall is high; a mapped key enters the
// item queue at the accepting edge and then moves to the output register when it is free.
// Prefix bytes and unmapped codes produce no item.
// rst is synchronous and clears the modifier flags, the queue and out_valid,
// and loads the default characters. cfg_ready is always high.
// in_stall rises only when the queue is full behind a stalled output.
module ps2_set1_scancode_decoder_unit #(
  parameter int QUEUE_DEPTH = ps2d_pkg::QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [ps2d_pkg::SCAN_W-1:0]     scan_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 is_release,
  output logic [ps2d_pkg::KEY_W-1:0]           key_id,
  output logic [ps2d_pkg::CHAR_W-1:0]          ascii_char,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ps2d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ps2d_pkg::CHAR_W-1:0]     cfg_data
);

  ps2d_pkg::ps2d_queue_status_t q_status;
  ps2d_pkg::ps2d_item_t         push_item, pop_item;
  logic                         push, pop;

  ps2d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .scan_byte (scan_byte),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  ps2d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  ps2d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_status   (q_status),
    .pop_item   (pop_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .is_release (is_release),
    .key_id     (key_id),
    .ascii_char (ascii_char)
  );

endmodule

`default_nettype wire

/* sv/ps2d_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module ps2d_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic                            is_release,
  input wire logic [ps2d_pkg::KEY_W-1:0]      key_id,
  input wire logic [ps2d_pkg::CHAR_W-1:0]     ascii_char
);

  // A held item keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(key_id)
      && $stable(is_release) && $stable(ascii_char))
    else $error("output item changed while stalled");

  a_key_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (key_id != ps2d_pkg::KEY_UNMAPPED) && (key_id <= ps2d_pkg::KEY_MAX))
    else $error("key_id outside the keycode range");

  a_release_no_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_release |-> ascii_char == '0)
    else $error("release carries a character");

  // Modifiers and arrows never print anything on a press.
  a_silent_keys: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_release && (key_id == ps2d_pkg::KEY_LSH
      || key_id == ps2d_pkg::KEY_RSH || key_id == ps2d_pkg::KEY_CAPS
      || key_id == ps2d_pkg::KEY_ALT || key_id == ps2d_pkg::KEY_CTRL
      || key_id == ps2d_pkg::KEY_ARROW_UP || key_id == ps2d_pkg::KEY_ARROW_DN
      || key_id == ps2d_pkg::KEY_ARROW_LT || key_id == ps2d_pkg::KEY_ARROW_RT)
      |-> ascii_char == '0)
    else $error("non-printing key gave a character");

endmodule

bind ps2_set1_scancode_decoder_unit ps2d_checker u_checker (.*);

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic                          is_release;
    logic [ps2d_pkg::KEY_W-1:0]    key_id;
    logic [ps2d_pkg::CHAR_W-1:0]   ascii_char;
  } kbd_event_t;

  typedef enum logic [1:0] {
    ROW_SILENT,
    ROW_TYPED,
    ROW_MODEL
  } row_kind_t;

  typedef struct packed {
    logic [ps2d_pkg::SCAN_W-1:0] scan;
    row_kind_t                   kind;
    kbd_event_t                  ev;
  } scan_row_t;

  localparam int DIRECTED_ROWS = 25;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int PHASES = 7;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [ps2d_pkg::SCAN_W-1:0]      scan_byte = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             is_release;
  logic [ps2d_pkg::KEY_W-1:0]       key_id;
  logic [ps2d_pkg::CHAR_W-1:0]      ascii_char;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [ps2d_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [ps2d_pkg::CHAR_W-1:0]      cfg_data = '0;

  ps2_set1_scancode_decoder_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .scan_byte  (scan_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .is_release (is_release),
    .key_id     (key_id),
    .ascii_char (ascii_char),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Decoder state as the keyboard side sees it.
  logic [ps2d_pkg::KEY_W-1:0]  base_key [128];
  logic [ps2d_pkg::CHAR_W-1:0] special_char [4];
  logic              prefix_armed, lshift_down, rshift_down, ctrl_pressed, caps_on;

  // Unshifted glyph per keycode; a tilde marks a key with no fixed glyph.
  string key_glyphs = "~~1234567890~~qwertyuiop~asdfghjkl~zxcvbnm~~ ";
  string digit_shifted = "!@#$%^&*()";

  kbd_event_t expected_events [$];
  kbd_event_t seen_event, due_event;
  scan_row_t  directed_rows [DIRECTED_ROWS];
  int         mismatches = 0;
  int         items_sent = 0;
  bit         in_calm = 1'b0;
  bit         out_calm = 1'b0;
  int         stall_left = 0;
  int         cycle_count = 0;

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("ERROR at %0t ns: %s", $time, what);
  endtask

  task automatic map_range(input int first_code, input int last_code, input int first_key);
    for (int c = first_code; c <= last_code; c++)
      base_key[c] = ps2d_pkg::KEY_W'(first_key + c - first_code);
  endtask

  function automatic logic [ps2d_pkg::KEY_W-1:0] extended_key(input logic [6:0] code);
    case (code)
      7'h48:   return ps2d_pkg::KEY_ARROW_UP;
      7'h50:   return ps2d_pkg::KEY_ARROW_DN;
      7'h4B:   return ps2d_pkg::KEY_ARROW_LT;
      7'h4D:   return ps2d_pkg::KEY_ARROW_RT;
      7'h1D:   return ps2d_pkg::KEY_CTRL;
      7'h38:   return ps2d_pkg::KEY_ALT;
      default: return ps2d_pkg::KEY_UNMAPPED;
    endcase
  endfunction

  // Advances the decoder state by one byte and forms the key event, if any.
  task automatic decode_scan(input logic [ps2d_pkg::SCAN_W-1:0] b, output logic produced,
                             output kbd_event_t ev);
    logic [ps2d_pkg::KEY_W-1:0] key;
    logic                       shift;
    byte                        glyph;
    produced = 1'b0;
    ev = '0;
    if (b == ps2d_pkg::CODE_EXT) begin
      prefix_armed = 1'b1;
    end else if (b == ps2d_pkg::CODE_PAUSE) begin
      prefix_armed = 1'b0;
    end else begin
      if (prefix_armed) begin
        key = extended_key(b[6:0]);
        prefix_armed = 1'b0;
      end else begin
        key = base_key[b[6:0]];
      end
      if (key != ps2d_pkg::KEY_UNMAPPED) begin
        case (key)
          ps2d_pkg::KEY_LSH:  lshift_down = !b[7];
          ps2d_pkg::KEY_RSH:  rshift_down = !b[7];
          ps2d_pkg::KEY_CTRL: ctrl_pressed = !b[7];
          ps2d_pkg::KEY_CAPS: if (!b[7]) caps_on = !caps_on;
          default: ;
        endcase
        produced = 1'b1;
        ev.is_release = b[7];
        ev.key_id = key;
        shift = lshift_down | rshift_down;
        if (!b[7]) begin
          case (key)
            ps2d_pkg::KEY_RETURN: ev.ascii_char = special_char[ps2d_pkg::CFG_ENTER];
            ps2d_pkg::KEY_BKSP:   ev.ascii_char = special_char[ps2d_pkg::CFG_BKSP];
            ps2d_pkg::KEY_TAB:    ev.ascii_char = special_char[ps2d_pkg::CFG_TAB];
            ps2d_pkg::KEY_ESC:    ev.ascii_char = special_char[ps2d_pkg::CFG_ESC];
            default: begin
              glyph = (key < ps2d_pkg::KEY_W'(key_glyphs.len())) ?
                      key_glyphs[int'(key)] : "~";
              if (glyph == "~") glyph = 8'd0;
              if (glyph >= "a" && glyph <= "z") begin
                if (ctrl_pressed) glyph = glyph - 8'h60;
                else if (shift != caps_on) glyph = glyph - 8'h20;
              end else if (shift && key >= 6'd2 && key <= 6'd11) begin
                glyph = digit_shifted[int'(key) - 2];
              end
              ev.ascii_char = glyph[6:0];
            end
          endcase
        end
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (in_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offers one byte and returns at the edge where it is taken.
  task automatic send_byte(input logic [ps2d_pkg::SCAN_W-1:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    scan_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic feed_byte(input logic [ps2d_pkg::SCAN_W-1:0] b);
    logic       produced;
    kbd_event_t ev;
    send_byte(b);
    decode_scan(b, produced, ev);
    if (produced) expected_events.push_back(ev);
    items_sent++;
  endtask

  // Lets every expected event arrive, then a few cycles more for bytes in flight.
  task automatic wait_idle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (expected_events.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
    if (expected_events.size() != 0) begin
      flag_mismatch($sformatf("%0d key events never arrived", expected_events.size()));
      expected_events.delete();
    end
  endtask

  task automatic write_config(input logic [ps2d_pkg::CHAR_W-1:0] enter_v,
                              input logic [ps2d_pkg::CHAR_W-1:0] bksp_v,
                              input logic [ps2d_pkg::CHAR_W-1:0] tab_v,
                              input logic [ps2d_pkg::CHAR_W-1:0] esc_v);
    logic [ps2d_pkg::CHAR_W-1:0] vals [4];
    vals[ps2d_pkg::CFG_ENTER] = enter_v;
    vals[ps2d_pkg::CFG_BKSP] = bksp_v;
    vals[ps2d_pkg::CFG_TAB] = tab_v;
    vals[ps2d_pkg::CFG_ESC] = esc_v;
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= ps2d_pkg::cfg_idx_t'(i);
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      special_char[i] = vals[i];
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed key strokes, with some noise and broken prefix sequences.
  task automatic send_random_event();
    int         r;
    logic       rel;
    logic [6:0] code;
    r = $urandom_range(0, 99);
    rel = ($urandom_range(0, 3) == 0);
    if (r < 12) begin
      feed_byte(ps2d_pkg::SCAN_W'($urandom_range(0, 255)));
    end else if (r < 30) begin
      rel = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0: feed_byte({rel, 7'h2A});
        1: feed_byte({rel, 7'h36});
        2: feed_byte({rel, 7'h3A});
        default: begin
          feed_byte(ps2d_pkg::CODE_EXT);
          feed_byte({rel, 7'h1D});
        end
      endcase
    end else if (r < 45) begin
      feed_byte(ps2d_pkg::CODE_EXT);
      case ($urandom_range(0, 5))
        0: code = 7'h48;
        1: code = 7'h50;
        2: code = 7'h4B;
        3: code = 7'h4D;
        4: code = 7'h1D;
        default: code = 7'h38;
      endcase
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 2))
          0: feed_byte(ps2d_pkg::CODE_EXT);
          1: feed_byte(ps2d_pkg::CODE_PAUSE);
          default: code = 7'($urandom_range(0, 127));
        endcase
      end
      feed_byte({rel, code});
    end else begin
      do code = 7'($urandom_range(0, 127)); while (base_key[code] == ps2d_pkg::KEY_UNMAPPED);
      feed_byte({rel, code});
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count % 256 == 0) out_calm = ($urandom_range(0, 3) == 0);
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!out_calm && $urandom_range(0, 3) == 0) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_event = '{is_release, key_id, ascii_char};
      if (expected_events.size() == 0) begin
        flag_mismatch($sformatf("unexpected key event rel=%0b key=%0d char=%0h",
                                is_release, key_id, ascii_char));
      end else begin
        due_event = expected_events.pop_front();
        if (seen_event.is_release != due_event.is_release ||
            seen_event.key_id != due_event.key_id ||
            seen_event.ascii_char != due_event.ascii_char)
          flag_mismatch($sformatf("expected rel=%0b key=%0d char=%0h, got rel=%0b key=%0d char=%0h",
                                  due_event.is_release, due_event.key_id, due_event.ascii_char,
                                  seen_event.is_release, seen_event.key_id,
                                  seen_event.ascii_char));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("ps2_set1_scancode_decoder_unit test failed");
    $finish;
  end

  initial begin
    scan_row_t  row;
    logic       produced;
    kbd_event_t ev;
    for (int c = 0; c < 128; c++) base_key[c] = ps2d_pkg::KEY_UNMAPPED;
    map_range(8'h01, 8'h01, 1);
    map_range(8'h02, 8'h0B, 2);
    map_range(8'h0E, 8'h19, 12);
    map_range(8'h1C, 8'h1C, 24);
    map_range(8'h1E, 8'h26, 25);
    map_range(8'h2A, 8'h2A, 34);
    map_range(8'h2C, 8'h32, 35);
    map_range(8'h36, 8'h36, 42);
    map_range(8'h38, 8'h44, 43);
    map_range(8'h57, 8'h58, 56);
    special_char[ps2d_pkg::CFG_ENTER] = 7'd10;
    special_char[ps2d_pkg::CFG_BKSP] = 7'd8;
    special_char[ps2d_pkg::CFG_TAB] = 7'd9;
    special_char[ps2d_pkg::CFG_ESC] = 7'd27;
    {prefix_armed, lshift_down, rshift_down, ctrl_pressed, caps_on} = '0;

    // Typed rows hold what the default settings give; the rest follow the tracked state.
    directed_rows = '{
      {8'h01,                ROW_TYPED,  1'b0, ps2d_pkg::KEY_ESC,      7'd27},
      {8'h81,                ROW_TYPED,  1'b1, ps2d_pkg::KEY_ESC,      7'd0},
      {8'h1C,                ROW_TYPED,  1'b0, ps2d_pkg::KEY_RETURN,   7'd10},
      {8'h00,                ROW_SILENT, 14'd0},
      {8'hFF,                ROW_SILENT, 14'd0},
      {8'h1E,                ROW_TYPED,  1'b0, 6'd25,                  7'h61},
      {8'h2A,                ROW_TYPED,  1'b0, ps2d_pkg::KEY_LSH,      7'd0},
      {8'h1E,                ROW_MODEL,  14'd0},
      {8'h02,                ROW_MODEL,  14'd0},
      {8'h3A,                ROW_TYPED,  1'b0, ps2d_pkg::KEY_CAPS,     7'd0},
      {8'h1E,                ROW_MODEL,  14'd0},
      {8'hAA,                ROW_TYPED,  1'b1, ps2d_pkg::KEY_LSH,      7'd0},
      {ps2d_pkg::CODE_EXT,   ROW_SILENT, 14'd0},
      {8'h1D,                ROW_TYPED,  1'b0, ps2d_pkg::KEY_CTRL,     7'd0},
      {8'h2E,                ROW_MODEL,  14'd0},
      {ps2d_pkg::CODE_EXT,   ROW_SILENT, 14'd0},
      {ps2d_pkg::CODE_EXT,   ROW_SILENT, 14'd0},
      {8'h9D,                ROW_TYPED,  1'b1, ps2d_pkg::KEY_CTRL,     7'd0},
      {ps2d_pkg::CODE_EXT,   ROW_SILENT, 14'd0},
      {8'h38,                ROW_TYPED,  1'b0, ps2d_pkg::KEY_ALT,      7'd0},
      {ps2d_pkg::CODE_EXT,   ROW_SILENT, 14'd0},
      {8'h48,                ROW_TYPED,  1'b0, ps2d_pkg::KEY_ARROW_UP, 7'd0},
      {ps2d_pkg::CODE_EXT,   ROW_SILENT, 14'd0},
      {ps2d_pkg::CODE_PAUSE, ROW_SILENT, 14'd0},
      {8'h48,                ROW_SILENT, 14'd0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_rows[i];
      send_byte(row.scan);
      decode_scan(row.scan, produced, ev);
      case (row.kind)
        ROW_TYPED: expected_events.push_back(row.ev);
        ROW_MODEL: if (produced) expected_events.push_back(ev);
        default: ;
      endcase
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      int target;
      if (phase > 0) begin
        wait_idle();
        case (phase)
          1: write_config(7'd0, 7'd0, 7'd0, 7'd0);
          2: write_config(7'd127, 7'd127, 7'd127, 7'd127);
          default: write_config(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                                7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
        endcase
      end
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        if ($urandom_range(0, 39) == 0) in_calm = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 199) == 0) wait_idle();
        send_random_event();
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("ps2_set1_scancode_decoder_unit test passed");
    end else begin
      $display("ps2_set1_scancode_decoder_unit test failed");
    end
    $finish;
  end

endmodule
